[hw/rtl/eb32f_pkg.sv]
// Shared types, constants and functions of the encrypted base32 frame encoder.
package eb32f_pkg;

    localparam int BLK_BYTES   = 16;
    localparam int BLK_BITS    = 128;
    localparam int AES_ROUNDS  = 10;
    localparam int SYM_COUNT   = 26;
    localparam logic [7:0] PAYLOAD_MAX = 8'd252;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0] SEP_CHAR    = 8'h2E;
    localparam logic [7:0] RCON_INIT   = 8'h01;

    // Register indexes on the configuration port (address bits 5:3).
    localparam logic [2:0] REG_KEY_LOW  = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH = 3'd1;
    localparam logic [2:0] REG_TABLE_0  = 3'd2;
    localparam logic [2:0] REG_TABLE_1  = 3'd3;
    localparam logic [2:0] REG_TABLE_2  = 3'd4;
    localparam logic [2:0] REG_TABLE_3  = 3'd5;

    typedef struct packed {
        logic start;
        logic fin;
        logic ovf;
    } ser_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // One byte of CRC-16/Modbus, bit by bit.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/encrypted_base32_frame_encoder.sv]
// Top level: block assembly, CRC, frame closing sequencer and configuration registers.
//
//  channel  | ports                | tdata            | tlast      | tuser
//  input    | s_tvalid/s_tready    | data_byte [7:0]  | last       | empty_message
//  output   | m_tvalid/m_tready    | symbol [7:0]     | final_res  | overflow
//  config   | APB, 64-bit, reg i at byte address 8*i
//
// A byte that does not complete a block is taken while idle. A full block passes a start state,
// the shared AES round unit (ten rounds, then done) and the serialiser (27 words, then it
// hands back to the sequencer); closing a frame adds one or two blocks, each a close state
// followed by the same path.
// Output stalls hold the serialiser and with it the sequencer; no input is taken meanwhile.
// Reset is synchronous and needs no clearing pass.
module encrypted_base32_frame_encoder
    import eb32f_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tlast,
    input  logic        s_tuser,   // empty_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // symbol [7:0]
    output logic        m_tlast,
    output logic        m_tuser,   // overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLOSE = 5'b00010,
        ST_START = 5'b00100,
        ST_AES   = 5'b01000,
        ST_SER   = 5'b10000
    } state_t;

    state_t      state_reg;
    logic [63:0] key_lo_reg, key_hi_reg;
    logic [63:0] tbl_reg [4];
    logic [7:0]  blk_reg [BLK_BYTES];
    logic [3:0]  fill_reg;
    logic [15:0] crc_reg;
    logic [7:0]  count_reg;
    logic        ovf_reg, close_reg, fin_reg;
    logic [BLK_BITS-1:0] blk_vec, cipher;
    logic        accept, take, aes_done, ser_busy, cfg_wr;
    ser_ctl_t    ser_ctl;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign take     = !s_tuser && (count_reg < PAYLOAD_MAX);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        for (int i = 0; i < BLK_BYTES; i++) begin
            blk_vec[i*8 +: 8] = blk_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_lo_reg <= 64'd0;
            key_hi_reg <= 64'd0;
            for (int i = 0; i < 4; i++) begin
                tbl_reg[i] <= 64'd0;
            end
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_KEY_LOW:  key_lo_reg <= pwdata;
                REG_KEY_HIGH: key_hi_reg <= pwdata;
                REG_TABLE_0:  tbl_reg[0] <= pwdata;
                REG_TABLE_1:  tbl_reg[1] <= pwdata;
                REG_TABLE_2:  tbl_reg[2] <= pwdata;
                REG_TABLE_3:  tbl_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_KEY_LOW:  prdata = key_lo_reg;
            REG_KEY_HIGH: prdata = key_hi_reg;
            REG_TABLE_0:  prdata = tbl_reg[0];
            REG_TABLE_1:  prdata = tbl_reg[1];
            REG_TABLE_2:  prdata = tbl_reg[2];
            REG_TABLE_3:  prdata = tbl_reg[3];
            default:      prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= 4'd0;
            crc_reg   <= CRC_INIT;
            count_reg <= 8'd0;
            ovf_reg   <= 1'b0;
            close_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        close_reg <= s_tuser || s_tlast;
                        fin_reg   <= 1'b0;
                        if (!s_tuser && !take) begin
                            ovf_reg <= 1'b1;
                        end
                        if (take) begin
                            crc_reg   <= crc_byte(crc_reg, s_tdata);
                            fill_reg  <= fill_reg + 4'd1;
                            count_reg <= count_reg + 8'd1;
                        end
                        if (take && fill_reg == 4'(BLK_BYTES - 1)) begin
                            state_reg <= ST_START;
                        end else if (s_tuser || s_tlast) begin
                            state_reg <= ST_CLOSE;
                        end
                    end
                end
                ST_CLOSE: begin
                    // With no room for the trailer (more than 13 bytes held), flush a padded block first.
                    fin_reg   <= (fill_reg <= 4'd13);
                    fill_reg  <= 4'd0;
                    state_reg <= ST_START;
                end
                ST_START: state_reg <= ST_AES;
                ST_AES: begin
                    if (aes_done) begin
                        state_reg <= ST_SER;
                    end
                end
                ST_SER: begin
                    if (!ser_busy) begin
                        if (fin_reg) begin
                            crc_reg   <= CRC_INIT;
                            count_reg <= 8'd0;
                            ovf_reg   <= 1'b0;
                            close_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else if (close_reg) begin
                            state_reg <= ST_CLOSE;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept && take) begin
            blk_reg[fill_reg] <= s_tdata;
        end
        if (state_reg == ST_CLOSE) begin
            for (int i = 0; i < BLK_BYTES; i++) begin
                if (4'(i) >= fill_reg) begin
                    blk_reg[i] <= 8'h00;
                end
            end
            if (fill_reg <= 4'd13) begin
                blk_reg[13] <= count_reg;
                blk_reg[14] <= crc_reg[15:8];
                blk_reg[15] <= crc_reg[7:0];
            end
        end
    end

    eb32f_aes u_aes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_START),
        .blk_in  (blk_vec),
        .key     ({key_hi_reg, key_lo_reg}),
        .done    (aes_done),
        .blk_out (cipher)
    );

    assign ser_ctl.start = (state_reg == ST_AES) && aes_done;
    assign ser_ctl.fin   = fin_reg;
    assign ser_ctl.ovf   = ovf_reg;

    eb32f_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ser_ctl),
        .cipher   (cipher),
        .char_tbl ({tbl_reg[3], tbl_reg[2], tbl_reg[1], tbl_reg[0]}),
        .busy     (ser_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hw/rtl/eb32f_aes.sv]
// Iterative AES-128 encryption core: one round per cycle, round keys made on the fly.
module eb32f_aes
    import eb32f_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [BLK_BITS-1:0] blk_in,
    input  logic [BLK_BITS-1:0] key,
    output logic                done,
    output logic [BLK_BITS-1:0] blk_out
);

    logic [BLK_BITS-1:0] st_reg, rk_reg, st_next, rk_next, sub;
    logic [7:0]          rcon_reg;
    logic [3:0]          rnd_reg;
    logic                busy_reg, done_reg;
    logic [7:0]          a0, a1, a2, a3, x;
    logic [31:0]         g;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                sub[(c*4+j)*8 +: 8] = SBOX[st_reg[((((c+j) & 3)*4)+j)*8 +: 8]];
            end
        end
        st_next = sub;
        if (rnd_reg != 4'(AES_ROUNDS)) begin
            for (int c = 0; c < 4; c++) begin
                a0 = sub[(c*4)*8 +: 8];
                a1 = sub[(c*4+1)*8 +: 8];
                a2 = sub[(c*4+2)*8 +: 8];
                a3 = sub[(c*4+3)*8 +: 8];
                x  = a0 ^ a1 ^ a2 ^ a3;
                st_next[(c*4)*8 +: 8]   = a0 ^ x ^ xt(a0 ^ a1);
                st_next[(c*4+1)*8 +: 8] = a1 ^ x ^ xt(a1 ^ a2);
                st_next[(c*4+2)*8 +: 8] = a2 ^ x ^ xt(a2 ^ a3);
                st_next[(c*4+3)*8 +: 8] = a3 ^ x ^ xt(a3 ^ a0);
            end
        end else begin
            a0 = 8'h00;
            a1 = 8'h00;
            a2 = 8'h00;
            a3 = 8'h00;
            x  = 8'h00;
        end
        // Rotated and substituted last word of the previous round key.
        g = {SBOX[rk_reg[103:96]], SBOX[rk_reg[127:120]], SBOX[rk_reg[119:112]],
             SBOX[rk_reg[111:104]] ^ rcon_reg};
        rk_next[31:0]   = rk_reg[31:0] ^ g;
        rk_next[63:32]  = rk_reg[63:32] ^ rk_next[31:0];
        rk_next[95:64]  = rk_reg[95:64] ^ rk_next[63:32];
        rk_next[127:96] = rk_reg[127:96] ^ rk_next[95:64];
        st_next = st_next ^ rk_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == 4'(AES_ROUNDS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            st_reg   <= blk_in ^ key;
            rk_reg   <= key;
            rcon_reg <= RCON_INIT;
        end else if (busy_reg) begin
            st_reg   <= st_next;
            rk_reg   <= rk_next;
            rcon_reg <= xt(rcon_reg);
        end
    end

    assign done    = done_reg;
    assign blk_out = st_reg;

endmodule

[hw/rtl/eb32f_ser.sv]
// Cuts a ciphertext block into five-bit codes, sends their table words, then a separator.
module eb32f_ser
    import eb32f_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ser_ctl_t            ctl,
    input  logic [BLK_BITS-1:0] cipher,
    input  logic [255:0]        char_tbl,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic [BLK_BITS-1:0] sh_reg;
    logic [4:0]          cnt_reg;
    logic                busy_reg, fin_reg, ovf_reg, vld_reg, last_reg, user_reg;
    logic [7:0]          data_reg;
    logic                load;

    assign load = busy_reg && (!vld_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (load) begin
                if (cnt_reg == 5'(SYM_COUNT)) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            if (load) begin
                vld_reg <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            sh_reg  <= cipher;
            fin_reg <= ctl.fin;
            ovf_reg <= ctl.ovf;
        end else if (load) begin
            // Zeros shift in, so the last code keeps only three real bits.
            sh_reg <= sh_reg >> 5;
        end
        if (load) begin
            user_reg <= ovf_reg;
            if (cnt_reg == 5'(SYM_COUNT)) begin
                data_reg <= SEP_CHAR;
                last_reg <= fin_reg;
            end else begin
                data_reg <= char_tbl[{sh_reg[4:0], 3'b000} +: 8];
                last_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

[hw/rtl/eb32f_checker.sv]
// Port-level checks of the encoder, bound to the top level.
module eb32f_checker
    import eb32f_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // The frame-closing word is always the separator.
    a_last_is_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == SEP_CHAR)
        else $error("final word is not the separator");

    // An empty message always produces a block, so the input closes at once.
    a_empty_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input still open after an empty message");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not quiet after reset");

endmodule

bind encrypted_base32_frame_encoder eb32f_checker u_eb32f_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
